@@ rtl/bmws_pkg.sv @@
// ----------------------------------------------------------------------------
// bmws_pkg
// Shared types, constants and state codes for the bucketed window statistics.
// ----------------------------------------------------------------------------
package bmws_pkg;

    localparam int BUCKETS = 64;
    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int NB_W    = $clog2(BUCKETS + 1);
    localparam int ENT_W   = 64 + 64 + 64 + 32;

    localparam logic [15:0] MS_RESET = 16'd100;
    localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SMALL = 2'd1;
    localparam logic [1:0] ST_FIRST = 2'd2;
    localparam logic [1:0] ST_LARGE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [31:0] elapsed_ms;
        logic [31:0] window_ms;
        logic        use_full_window;
    } req_t;

    typedef struct packed {
        logic [63:0] max_sample;
        logic [63:0] min_sample;
        logic [31:0] sample_count;
        logic [6:0]  window_buckets;
        logic [63:0] window_sum;
        logic [63:0] max_bucket_sum;
        logic [63:0] min_bucket_sum;
        logic [63:0] avg_per_bucket;
        logic [63:0] avg_per_sample;
        logic [63:0] total_ever;
        logic [62:0] count_ever;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [63:0] bmax;
        logic [63:0] bmin;
        logic [63:0] bsum;
        logic [31:0] bcnt;
    } ent_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV1, S_DIV2, S_DECIDE, S_CLEAR, S_SRD, S_SWAIT, S_SWR,
        S_QSETUP, S_QRD, S_QWAIT, S_QACC, S_AVG1, S_AVG2, S_AVG3, S_AVG4, S_DONE
    } state_t;

    // 64-bit divider handshake
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/bmws_ram.sv @@
// ----------------------------------------------------------------------------
// bmws_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bmws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/bmws_div.sv @@
// ----------------------------------------------------------------------------
// bmws_div
// Restoring divider, one quotient bit per cycle, 64 by 64 bits.
// ----------------------------------------------------------------------------
module bmws_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bmws_pkg::div_req_t req,
    output bmws_pkg::div_rsp_t rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    // one shift-subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 7'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/bmws_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmws_ctrl
// Sequencer: bucket lookup, lazy clearing, sample update, window scan and
// average computation, sharing one divider.
// ----------------------------------------------------------------------------
module bmws_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  bmws_pkg::req_t             req,
    input  logic [15:0]                ms_per_bucket,
    output logic                       busy,
    output logic                       done,
    output bmws_pkg::rsp_t             rsp,
    output bmws_pkg::div_req_t         dreq,
    input  bmws_pkg::div_rsp_t         drsp,
    output logic                       ram_we,
    output logic [bmws_pkg::IDX_W-1:0] ram_addr,
    output bmws_pkg::ent_t             ram_wdata,
    input  bmws_pkg::ent_t             ram_rdata
);

    localparam int IW = bmws_pkg::IDX_W;

    bmws_pkg::state_t state_reg, state_next;
    bmws_pkg::req_t   req_reg;
    logic [31:0] now_reg, now_next;
    logic [31:0] nb_reg, nb_next;
    logic [32:0] ncb_reg, ncb_next;
    logic [32:0] clr_tgt_reg, clr_tgt_next;
    logic [IW:0] clr_left_reg, clr_left_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic [IW:0] scan_left_reg, scan_left_next;
    logic [63:0] tot_reg, tot_next;
    logic [63:0] cntall_reg, cntall_next;
    logic [63:0] mx_reg, mx_next, mn_reg, mn_next;
    logic [63:0] bmx_reg, bmx_next, bmn_reg, bmn_next;
    logic [63:0] sum_reg, sum_next, cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic        neg_reg, neg_next;
    logic        second_reg, second_next;
    logic [63:0] apb_reg, apb_next, aps_reg, aps_next;
    logic [1:0]  status_reg, status_next;
    logic        done_reg, done_next;
    logic [63:0] v64;
    logic [15:0] len;
    logic [32:0] n_clr;
    logic [63:0] res_avg;

    assign len = (ms_per_bucket == 16'd0) ? 16'd1 : ms_per_bucket;
    assign v64 = {{32{req_reg.value[31]}}, req_reg.value};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmws_pkg::S_IDLE:   if (start) state_next = bmws_pkg::S_DIV1;
            bmws_pkg::S_DIV1:   if (drsp.done)
                                    state_next = req_reg.kind ? bmws_pkg::S_DIV2
                                                              : bmws_pkg::S_DECIDE;
            bmws_pkg::S_DIV2:   if (drsp.done || req_reg.use_full_window)
                                    state_next = bmws_pkg::S_DECIDE;
            bmws_pkg::S_DECIDE:
            begin
                if (req_reg.kind && status_next != bmws_pkg::ST_OK)
                    state_next = bmws_pkg::S_DONE;
                else
                    state_next = bmws_pkg::S_CLEAR;
            end
            bmws_pkg::S_CLEAR:
            begin
                if (clr_left_reg == '0)
                    state_next = req_reg.kind ? bmws_pkg::S_QSETUP : bmws_pkg::S_SRD;
            end
            bmws_pkg::S_SRD:    state_next = bmws_pkg::S_SWAIT;
            bmws_pkg::S_SWAIT:  state_next = bmws_pkg::S_SWR;
            bmws_pkg::S_SWR:    state_next = bmws_pkg::S_IDLE;
            bmws_pkg::S_QSETUP: state_next = bmws_pkg::S_QRD;
            bmws_pkg::S_QRD:    state_next = bmws_pkg::S_QWAIT;
            bmws_pkg::S_QWAIT:  state_next = bmws_pkg::S_QACC;
            bmws_pkg::S_QACC:   state_next = (scan_left_reg == 1) ? bmws_pkg::S_AVG1
                                                                  : bmws_pkg::S_QRD;
            bmws_pkg::S_AVG1:   state_next = bmws_pkg::S_AVG2;
            bmws_pkg::S_AVG2:   if (drsp.done) state_next = bmws_pkg::S_AVG3;
            bmws_pkg::S_AVG3:   if (drsp.done) state_next = bmws_pkg::S_AVG4;
            bmws_pkg::S_AVG4:   state_next = second_reg ? bmws_pkg::S_DONE
                                                        : bmws_pkg::S_AVG1;
            bmws_pkg::S_DONE:   state_next = bmws_pkg::S_IDLE;
            default:            state_next = bmws_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        now_next       = now_reg;
        nb_next        = nb_reg;
        ncb_next       = ncb_reg;
        clr_tgt_next   = clr_tgt_reg;
        clr_left_next  = clr_left_reg;
        addr_next      = addr_reg;
        scan_left_next = scan_left_reg;
        tot_next       = tot_reg;
        cntall_next    = cntall_reg;
        mx_next        = mx_reg;
        mn_next        = mn_reg;
        bmx_next       = bmx_reg;
        bmn_next       = bmn_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        second_next    = second_reg;
        apb_next       = apb_reg;
        aps_next       = aps_reg;
        status_next    = status_reg;
        done_next      = 1'b0;
        dreq           = '0;
        ram_we         = 1'b0;
        ram_addr       = addr_reg;
        ram_wdata      = '0;
        n_clr          = '0;
        res_avg        = '0;
        case (state_reg)
            bmws_pkg::S_IDLE:
            begin
                if (start)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = {32'd0, req.elapsed_ms};
                    dreq.den   = {48'd0, len};
                end
            end
            bmws_pkg::S_DIV1:
            begin
                if (drsp.done)
                begin
                    now_next = drsp.quo[31:0];
                    if (req_reg.kind)
                    begin
                        dreq.start = !req_reg.use_full_window;
                        dreq.num   = {32'd0, req_reg.window_ms};
                        dreq.den   = {48'd0, len};
                        nb_next    = 32'(bmws_pkg::BUCKETS / 2);
                    end
                end
            end
            bmws_pkg::S_DIV2:
            begin
                if (drsp.done && !req_reg.use_full_window)
                    nb_next = drsp.quo[31:0];
            end
            bmws_pkg::S_DECIDE:
            begin
                status_next = bmws_pkg::ST_OK;
                if (req_reg.kind)
                begin
                    if (nb_reg == 32'd0)
                        status_next = bmws_pkg::ST_SMALL;
                    else if (nb_reg > 32'(bmws_pkg::BUCKETS))
                        status_next = bmws_pkg::ST_LARGE;
                    else if (now_reg == 32'd0)
                        status_next = bmws_pkg::ST_FIRST;
                end
                // clear target b is now for a sample, now-1 for a query
                clr_tgt_next = req_reg.kind ? {1'b0, now_reg - 32'd1} : {1'b0, now_reg};
                clr_left_next = '0;
                if (clr_tgt_next >= ncb_reg)
                begin
                    n_clr = clr_tgt_next + 33'd1 - ncb_reg;
                    if (n_clr >= 33'(bmws_pkg::BUCKETS))
                    begin
                        clr_left_next = (IW+1)'(bmws_pkg::BUCKETS);
                        addr_next     = '0;
                    end
                    else
                    begin
                        clr_left_next = n_clr[IW:0];
                        addr_next     = ncb_reg[IW-1:0] + IW'(1);
                    end
                    if (!(req_reg.kind && status_next != bmws_pkg::ST_OK))
                        ncb_next = clr_tgt_next + 33'd1;
                end
            end
            bmws_pkg::S_CLEAR:
            begin
                if (clr_left_reg != '0)
                begin
                    ram_we         = 1'b1;
                    ram_wdata.bmax = bmws_pkg::S64_MIN;
                    ram_wdata.bmin = bmws_pkg::S64_MAX;
                    addr_next      = addr_reg + IW'(1);
                    clr_left_next  = clr_left_reg - 1'b1;
                end
                else
                begin
                    addr_next = req_reg.kind ? (clr_tgt_reg[IW-1:0] + IW'(1) - nb_reg[IW-1:0])
                                             : now_reg[IW-1:0];
                end
            end
            bmws_pkg::S_SWR:
            begin
                ram_we         = 1'b1;
                ram_wdata      = ram_rdata;
                if ($signed(v64) > $signed(ram_rdata.bmax)) ram_wdata.bmax = v64;
                if ($signed(v64) < $signed(ram_rdata.bmin)) ram_wdata.bmin = v64;
                ram_wdata.bsum = ram_rdata.bsum + v64;
                ram_wdata.bcnt = ram_rdata.bcnt + 32'd1;
                tot_next       = tot_reg + v64;
                cntall_next    = cntall_reg + 64'd1;
            end
            bmws_pkg::S_QSETUP:
            begin
                scan_left_next = nb_reg[IW:0];
                mx_next  = bmws_pkg::S64_MIN;
                mn_next  = bmws_pkg::S64_MAX;
                bmx_next = bmws_pkg::S64_MIN;
                bmn_next = bmws_pkg::S64_MAX;
                sum_next = '0;
                cnt_next = '0;
            end
            bmws_pkg::S_QACC:
            begin
                if ($signed(ram_rdata.bmax) > $signed(mx_reg)) mx_next = ram_rdata.bmax;
                if ($signed(ram_rdata.bmin) < $signed(mn_reg)) mn_next = ram_rdata.bmin;
                if ($signed(ram_rdata.bsum) > $signed(bmx_reg)) bmx_next = ram_rdata.bsum;
                if ($signed(ram_rdata.bsum) < $signed(bmn_reg)) bmn_next = ram_rdata.bsum;
                sum_next       = sum_reg + ram_rdata.bsum;
                cnt_next       = cnt_reg + {32'd0, ram_rdata.bcnt};
                addr_next      = addr_reg + IW'(1);
                scan_left_next = scan_left_reg - 1'b1;
                second_next    = 1'b0;
            end
            bmws_pkg::S_AVG1:
            begin
                neg_next   = sum_reg[63];
                dreq.start = 1'b1;
                dreq.num   = sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;
                dreq.den   = second_reg ? cnt_reg : {32'd0, nb_reg};
            end
            bmws_pkg::S_AVG2:
            begin
                if (drsp.done)
                begin
                    q_next     = drsp.quo;
                    dreq.start = 1'b1;
                    dreq.num   = {drsp.rem[55:0], 8'd0};
                    dreq.den   = second_reg ? cnt_reg : {32'd0, nb_reg};
                end
            end
            bmws_pkg::S_AVG3:
            begin
                if (drsp.done)
                begin
                    if (q_reg >= 64'h0080_0000_0000_0000)
                        res_avg = neg_reg ? bmws_pkg::S64_MIN : bmws_pkg::S64_MAX;
                    else
                    begin
                        res_avg = {q_reg[55:0], 8'd0} + drsp.quo;
                        if (neg_reg) res_avg = 64'd0 - res_avg;
                    end
                    if (second_reg) aps_next = (cnt_reg == 64'd0) ? 64'd0 : res_avg;
                    else apb_next = res_avg;
                end
            end
            bmws_pkg::S_AVG4:
            begin
                second_next = 1'b1;
            end
            bmws_pkg::S_DONE:
            begin
                done_next = 1'b1;
            end
            default: ;
        endcase
        // zero count: the second divide uses count one to avoid dividing by zero, result forced to zero
        if (state_reg == bmws_pkg::S_AVG1 && second_reg && cnt_reg == 64'd0)
            dreq.den = 64'd1;
        if (state_reg == bmws_pkg::S_AVG2 && second_reg && cnt_reg == 64'd0)
            dreq.den = 64'd1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bmws_pkg::S_IDLE;
            ncb_reg    <= '0;
            tot_reg    <= '0;
            cntall_reg <= '0;
            done_reg   <= 1'b0;
            clr_left_reg  <= (IW+1)'(bmws_pkg::BUCKETS);
            addr_reg      <= '0;
            scan_left_reg <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ncb_reg       <= ncb_next;
            tot_reg       <= tot_next;
            cntall_reg    <= cntall_next;
            done_reg      <= done_next;
            clr_left_reg  <= clr_left_next;
            addr_reg      <= addr_next;
            scan_left_reg <= scan_left_next;
            second_reg    <= second_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == bmws_pkg::S_IDLE && start)
            req_reg <= req;
        now_reg     <= now_next;
        nb_reg      <= nb_next;
        clr_tgt_reg <= clr_tgt_next;
        mx_reg      <= mx_next;
        mn_reg      <= mn_next;
        bmx_reg     <= bmx_next;
        bmn_reg     <= bmn_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        q_reg       <= q_next;
        neg_reg     <= neg_next;
        apb_reg     <= apb_next;
        aps_reg     <= aps_next;
        status_reg  <= status_next;
    end

    // result assembly
    always_comb
    begin
        rsp            = '0;
        rsp.total_ever = tot_reg;
        rsp.count_ever = cntall_reg[62:0];
        rsp.status     = status_reg;
        if (status_reg == bmws_pkg::ST_OK)
        begin
            rsp.max_sample     = mx_reg;
            rsp.min_sample     = mn_reg;
            rsp.sample_count   = cnt_reg[31:0];
            rsp.window_buckets = nb_reg[6:0];
            rsp.window_sum     = sum_reg;
            rsp.max_bucket_sum = bmx_reg;
            rsp.min_bucket_sum = bmn_reg;
            rsp.avg_per_bucket = apb_reg;
            rsp.avg_per_sample = aps_reg;
        end
    end

    assign busy = (state_reg != bmws_pkg::S_IDLE);
    assign done = done_reg;

endmodule

@@ rtl/bucketed_moving_window_stats.sv @@
// ----------------------------------------------------------------------------
// bucketed_moving_window_stats
// Time-bucketed sliding-window statistics over a ring of buckets.
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// request   start, busy, req               start && !busy
// result    result_valid, result           one-cycle strobe
// config    cfg_we, cfg_wdata              cfg_we
//
// A sample's time grows with the buckets cleared; a query's time grows with its
// window buckets and the buckets cleared and is shorter with the default window,
// which skips one divide. Both are set by the bit-serial divider, used once per
// sample and up to six times per query, and by the one-port bucket RAM.
// The bucket RAM is cleared after reset, every bucket in turn, busy meanwhile.
// Results cannot be stalled; each is shown for one cycle.
module bucketed_moving_window_stats (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bmws_pkg::req_t  req,
    output logic            result_valid,
    output bmws_pkg::rsp_t  result,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata
);

    logic [15:0]               ms_reg;
    bmws_pkg::div_req_t        dreq;
    bmws_pkg::div_rsp_t        drsp;
    logic                      ram_we;
    logic [bmws_pkg::IDX_W-1:0] ram_addr;
    bmws_pkg::ent_t            ram_wdata;
    bmws_pkg::ent_t            ram_rdata;
    logic [bmws_pkg::ENT_W-1:0] ram_q;
    logic                      ctrl_busy;
    logic                      init_reg;
    logic [bmws_pkg::IDX_W:0]  init_cnt_reg;
    logic                      ram_we_mux;
    logic [bmws_pkg::IDX_W-1:0] ram_addr_mux;
    bmws_pkg::ent_t            ram_wdata_mux;
    bmws_pkg::ent_t            clr_ent;

    // bucket length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ms_reg <= bmws_pkg::MS_RESET;
        else if (cfg_we)
            ms_reg <= cfg_wdata;
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= 1'b1;
            init_cnt_reg <= '0;
        end
        else if (init_reg)
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if (init_cnt_reg == (bmws_pkg::IDX_W+1)'(bmws_pkg::BUCKETS - 1))
                init_reg <= 1'b0;
        end
    end

    always_comb
    begin
        clr_ent      = '0;
        clr_ent.bmax = bmws_pkg::S64_MIN;
        clr_ent.bmin = bmws_pkg::S64_MAX;
    end

    assign ram_we_mux    = init_reg ? 1'b1 : ram_we;
    assign ram_addr_mux  = init_reg ? init_cnt_reg[bmws_pkg::IDX_W-1:0] : ram_addr;
    assign ram_wdata_mux = init_reg ? clr_ent : ram_wdata;
    assign ram_rdata     = ram_q;
    assign busy          = ctrl_busy || init_reg;

    bmws_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start && !init_reg),
        .req           (req),
        .ms_per_bucket (ms_reg),
        .busy          (ctrl_busy),
        .done          (result_valid),
        .rsp           (result),
        .dreq          (dreq),
        .drsp          (drsp),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata)
    );

    bmws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    bmws_ram #(
        .WIDTH (bmws_pkg::ENT_W),
        .DEPTH (bmws_pkg::BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we_mux),
        .addr  (ram_addr_mux),
        .wdata (ram_wdata_mux),
        .rdata (ram_q)
    );

endmodule
